// ===== src/iirdf1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_pkg: shared types, constants and microprogram
// Widths, coefficient reset values, control word layout and the control ROM
// of the third-order direct form I IIR filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 16;
  localparam int NUM_COEF  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int TAPS_DEF  = 4;
  localparam int TAP_W     = 2;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int RND_W     = ACC_W - COEF_FRAC;
  localparam int STEP_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_B3 = 3'd3,
    REG_A1 = 3'd4,
    REG_A2 = 3'd5,
    REG_A3 = 3'd6
  } cfg_reg_e;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
    18'sd6457, 18'sd19372, 18'sd19372, 18'sd6457,
    -18'sd37830, 18'sd27642, -18'sd3690
  };

  typedef enum logic [1:0] {
    SRC_SAMPLE = 2'd0,
    SRC_X      = 2'd1,
    SRC_Y      = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_WAIT_IN  = 2'd1,
    JMP_IF_CLR   = 2'd2,
    JMP_WAIT_OUT = 2'd3
  } jmp_e;

  localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DISP = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CLR  = 4'd10;

  // one control word of the program
  typedef struct packed {
    logic              in_rdy;
    logic              wr_x;
    src_e              src;
    logic [TAP_W-1:0]  tap;
    acc_op_e           op;
    logic              fin;
    logic              clr;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } uop_t;

  // sequencer to datapath
  typedef struct packed {
    logic             in_rdy;
    logic             wr_x;
    src_e             src;
    logic [TAP_W-1:0] tap;
    acc_op_e          op;
    logic             fin;
    logic             clr;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic cmd_clr;
    logic out_free;
  } stat_t;

  function automatic uop_t mk_uop(input logic in_rdy, input logic wr_x, input src_e src,
                                  input logic [TAP_W-1:0] tap, input acc_op_e op,
                                  input logic fin, input logic clr, input jmp_e jmp,
                                  input logic [STEP_W-1:0] target);
    uop_t u;
    u.in_rdy = in_rdy;
    u.wr_x   = wr_x;
    u.src    = src;
    u.tap    = tap;
    u.op     = op;
    u.fin    = fin;
    u.clr    = clr;
    u.jmp    = jmp;
    u.target = target;
    return u;
  endfunction

  // Filter program: b0 on the new sample, then b/a pairs for each older tap.
  // The product of each step is registered and accumulated in the following step.
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      4'd0:    u = mk_uop(1'b1, 1'b0, SRC_SAMPLE, 2'd0, ACC_NONE, 1'b0, 1'b0,
                          JMP_WAIT_IN, STEP_WAIT);
      4'd1:    u = mk_uop(1'b0, 1'b1, SRC_SAMPLE, 2'd0, ACC_LOAD, 1'b0, 1'b0,
                          JMP_IF_CLR, STEP_CLR);
      4'd2:    u = mk_uop(1'b0, 1'b0, SRC_X, 2'd1, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, STEP_WAIT);
      4'd3:    u = mk_uop(1'b0, 1'b0, SRC_Y, 2'd1, ACC_SUB, 1'b0, 1'b0, JMP_NEXT, STEP_WAIT);
      4'd4:    u = mk_uop(1'b0, 1'b0, SRC_X, 2'd2, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, STEP_WAIT);
      4'd5:    u = mk_uop(1'b0, 1'b0, SRC_Y, 2'd2, ACC_SUB, 1'b0, 1'b0, JMP_NEXT, STEP_WAIT);
      4'd6:    u = mk_uop(1'b0, 1'b0, SRC_X, 2'd3, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, STEP_WAIT);
      4'd7:    u = mk_uop(1'b0, 1'b0, SRC_Y, 2'd3, ACC_SUB, 1'b0, 1'b0, JMP_NEXT, STEP_WAIT);
      // drain the last product
      4'd8:    u = mk_uop(1'b0, 1'b0, SRC_SAMPLE, 2'd0, ACC_NONE, 1'b0, 1'b0,
                          JMP_NEXT, STEP_WAIT);
      4'd9:    u = mk_uop(1'b0, 1'b0, SRC_SAMPLE, 2'd0, ACC_NONE, 1'b1, 1'b0,
                          JMP_WAIT_OUT, STEP_WAIT);
      4'd10:   u = mk_uop(1'b0, 1'b0, SRC_SAMPLE, 2'd0, ACC_NONE, 1'b0, 1'b1,
                          JMP_WAIT_OUT, STEP_WAIT);
      default: u = mk_uop(1'b0, 1'b0, SRC_SAMPLE, 2'd0, ACC_NONE, 1'b0, 1'b0,
                          JMP_WAIT_OUT, STEP_WAIT);
    endcase
    return u;
  endfunction

endpackage

// ===== src/iirdf1_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_ifs: channel interfaces
// Sample input, filter result and coefficient write channels, valid/ready.
// ----------------------------------------------------------------------------
interface iirdf1_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    cmd;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, cmd, sample, input ready);
  modport sink   (input valid, cmd, sample, output ready);
endinterface

interface iirdf1_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  filtered;
  logic                                    clipped;
  modport source (output valid, filtered, clipped, input ready);
  modport sink   (input valid, filtered, clipped, output ready);
endinterface

interface iirdf1_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [iirdf1_pkg::CFG_IDX_W-1:0]   index;
  logic [iirdf1_pkg::COEF_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/iir_filter_direct_form_one.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one: third-order direct form I IIR filter
// Microcoded sequencer around one shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per command. cmd 0 filters sample (Q1.15), cmd 1 clears
//            the input/output histories and returns a zero result.
//   out_ch : one beat per command: filtered (Q1.15, rounded, saturated) and
//            clipped, set when the sum was saturated.
//   cfg_ch : coefficient writes, index 0..3 = b0..b3, 4..6 = a1..a3, signed
//            Q2.16; other indexes are dropped. Always ready; write while idle.
// Sequence:
//   A filter beat steps from accept through the b0 load, six b/a tap steps,
//   a drain step and the final step that writes the result; the 7-tap program
//   runs one multiply per step on the single multiplier. A clear beat goes from
//   its first step straight to the clear step. One command is in flight at a
//   time; in_ch.ready is high only in the program's wait step.
// Stall: the result is held in an output register; a finished result waits
//   there while the sequencer stalls in its final step until out_ch drains.
// Reset: coefficients return to their defaults, histories and ring position
//   to zero, no result pending.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one #(
  parameter int TAPS = iirdf1_pkg::TAPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  iirdf1_in_if.sink       in_ch,
  iirdf1_out_if.source    out_ch,
  iirdf1_cfg_if.sink      cfg_ch
);

  iirdf1_pkg::ctl_t  ctl;
  iirdf1_pkg::stat_t stat;

  assign in_ch.ready  = ctl.in_rdy;
  assign cfg_ch.ready = 1'b1;

  iirdf1_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  iirdf1_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .stat         (stat),
    .in_valid     (in_ch.valid),
    .in_cmd       (in_ch.cmd),
    .in_sample    (in_ch.sample),
    .cfg_valid    (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_filtered (out_ch.filtered),
    .out_clipped  (out_ch.clipped)
  );

  // the sequencer leaves its wait step right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a command is in flight");

  // a saturated result sits on a rail
  a_clip_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clipped |->
      (out_ch.filtered == 16'sh7fff || out_ch.filtered == 16'sh8000))
    else $error("clip flag without a saturated value");

  // results are only produced by a running program
  a_result_from_program: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared while the sequencer was waiting for input");

endmodule

// ===== src/iirdf1_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_seq: microprogram sequencer
// Step counter over the control ROM with wait and conditional jumps.
// ----------------------------------------------------------------------------
module iirdf1_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  iirdf1_pkg::stat_t   stat,
  output iirdf1_pkg::ctl_t    ctl
);

  logic [iirdf1_pkg::STEP_W-1:0] step_r;
  logic [iirdf1_pkg::STEP_W-1:0] step_nxt;
  iirdf1_pkg::uop_t              uop;

  assign uop = iirdf1_pkg::uop_rom(step_r);

  always_comb begin
    ctl.in_rdy = uop.in_rdy;
    ctl.wr_x   = uop.wr_x && !stat.cmd_clr;
    ctl.src    = uop.src;
    ctl.tap    = uop.tap;
    ctl.op     = uop.op;
    ctl.fin    = uop.fin && stat.out_free;
    ctl.clr    = uop.clr && stat.out_free;
    case (uop.jmp)
      iirdf1_pkg::JMP_NEXT:     step_nxt = step_r + 1'b1;
      iirdf1_pkg::JMP_WAIT_IN:  step_nxt = in_valid ? step_r + 1'b1 : step_r;
      iirdf1_pkg::JMP_IF_CLR:   step_nxt = stat.cmd_clr ? uop.target : step_r + 1'b1;
      iirdf1_pkg::JMP_WAIT_OUT: step_nxt = stat.out_free ? uop.target : step_r;
      default:                  step_nxt = iirdf1_pkg::STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= iirdf1_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== src/iirdf1_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_dp: filter datapath
// Coefficient file, sample histories, one multiplier, accumulator,
// round/saturate and the output register.
// ----------------------------------------------------------------------------
module iirdf1_dp #(
  parameter int TAPS = iirdf1_pkg::TAPS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  iirdf1_pkg::ctl_t                        ctl,
  output iirdf1_pkg::stat_t                       stat,
  input  logic                                    in_valid,
  input  logic                                    in_cmd,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                    cfg_valid,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [iirdf1_pkg::COEF_W-1:0]           cfg_data,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]  out_filtered,
  output logic                                    out_clipped
);

  localparam int SW = iirdf1_pkg::SAMPLE_W;
  localparam int PW = $clog2(TAPS);
  localparam int DW = $clog2(2 * TAPS);
  localparam int AW = iirdf1_pkg::ACC_W;
  localparam int RW = iirdf1_pkg::RND_W;
  localparam logic signed [AW-1:0] RND_ADD = AW'(2 ** (iirdf1_pkg::COEF_FRAC - 1));
  localparam logic signed [RW-1:0] Y_MAX   = RW'(2 ** (SW - 1) - 1);
  localparam logic signed [RW-1:0] Y_MIN   = RW'(-(2 ** (SW - 1)));

  logic signed [iirdf1_pkg::COEF_W-1:0] coef_r [iirdf1_pkg::NUM_COEF];
  logic signed [SW-1:0]                 x_hist_r [TAPS];
  logic signed [SW-1:0]                 y_hist_r [TAPS];
  logic [PW-1:0]                        pos_r;
  logic [PW-1:0]                        pos_nxt;
  logic signed [SW-1:0]                 sample_r;
  logic                                 cmd_r;
  logic signed [iirdf1_pkg::PROD_W-1:0] prod_r;
  logic signed [iirdf1_pkg::PROD_W-1:0] prod_nxt;
  iirdf1_pkg::acc_op_e                  prod_op_r;
  iirdf1_pkg::acc_op_e                  prod_op_nxt;
  logic signed [AW-1:0]                 acc_r;
  logic                                 out_valid_r;
  logic signed [SW-1:0]                 filt_r;
  logic                                 clip_r;

  logic                                 in_fire;
  logic                                 tap_live;
  logic [DW-1:0]                        slot_raw;
  logic [DW-1:0]                        slot;
  logic [iirdf1_pkg::CFG_IDX_W-1:0]     coef_idx;
  logic signed [iirdf1_pkg::COEF_W-1:0] coef_sel;
  logic signed [SW-1:0]                 opnd;
  logic signed [AW-1:0]                 acc_rnd;
  logic signed [RW-1:0]                 y_rnd;
  logic signed [SW-1:0]                 y_sat;
  logic                                 y_clip;

  assign in_fire = in_valid && ctl.in_rdy;

  // ring slot of tap k: (pos - k) mod TAPS
  always_comb begin
    slot_raw = DW'(pos_r) + DW'(TAPS) - DW'(ctl.tap);
    slot     = (slot_raw >= DW'(TAPS)) ? slot_raw - DW'(TAPS) : slot_raw;
    tap_live = {1'b0, ctl.tap} < 3'(TAPS);
    coef_idx = (ctl.src == iirdf1_pkg::SRC_Y) ? 3'(ctl.tap) + 3'd3 : {1'b0, ctl.tap};
    coef_sel = coef_r[coef_idx];
    case (ctl.src)
      iirdf1_pkg::SRC_X: opnd = x_hist_r[slot[PW-1:0]];
      iirdf1_pkg::SRC_Y: opnd = y_hist_r[slot[PW-1:0]];
      default:           opnd = sample_r;
    endcase
    prod_nxt    = coef_sel * opnd;
    prod_op_nxt = tap_live ? ctl.op : iirdf1_pkg::ACC_NONE;
  end

  // round half up, then clamp to the sample range
  always_comb begin
    acc_rnd = acc_r + RND_ADD;
    y_rnd   = $signed(acc_rnd[AW-1:iirdf1_pkg::COEF_FRAC]);
    y_clip  = 1'b0;
    if (y_rnd > Y_MAX) begin
      y_sat  = Y_MAX[SW-1:0];
      y_clip = 1'b1;
    end else if (y_rnd < Y_MIN) begin
      y_sat  = Y_MIN[SW-1:0];
      y_clip = 1'b1;
    end else begin
      y_sat  = y_rnd[SW-1:0];
    end
    pos_nxt = (pos_r == PW'(TAPS - 1)) ? '0 : pos_r + 1'b1;
  end

  assign stat.cmd_clr  = cmd_r;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iirdf1_pkg::NUM_COEF; i++) begin
        coef_r[i] <= iirdf1_pkg::COEF_RESET[i];
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        iirdf1_pkg::REG_B0, iirdf1_pkg::REG_B1, iirdf1_pkg::REG_B2, iirdf1_pkg::REG_B3,
        iirdf1_pkg::REG_A1, iirdf1_pkg::REG_A2, iirdf1_pkg::REG_A3: begin
          coef_r[cfg_index] <= $signed(cfg_data);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        x_hist_r[i] <= '0;
        y_hist_r[i] <= '0;
      end
      pos_r <= '0;
    end else if (ctl.clr) begin
      for (int i = 0; i < TAPS; i++) begin
        x_hist_r[i] <= '0;
        y_hist_r[i] <= '0;
      end
      pos_r <= '0;
    end else begin
      if (ctl.wr_x) begin
        x_hist_r[pos_r] <= sample_r;
      end
      if (ctl.fin) begin
        y_hist_r[pos_r] <= y_sat;
        pos_r           <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_sample;
      cmd_r    <= in_cmd;
    end
    prod_r <= prod_nxt;
    case (prod_op_r)
      iirdf1_pkg::ACC_LOAD: acc_r <= AW'(prod_r);
      iirdf1_pkg::ACC_ADD:  acc_r <= acc_r + AW'(prod_r);
      iirdf1_pkg::ACC_SUB:  acc_r <= acc_r - AW'(prod_r);
      default:              acc_r <= acc_r;
    endcase
    if (ctl.fin) begin
      filt_r <= y_sat;
      clip_r <= y_clip;
    end else if (ctl.clr) begin
      filt_r <= '0;
      clip_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_op_r   <= iirdf1_pkg::ACC_NONE;
      out_valid_r <= 1'b0;
    end else begin
      prod_op_r <= prod_op_nxt;
      if (ctl.fin || ctl.clr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = filt_r;
  assign out_clipped  = clip_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for iir_filter_direct_form_one
// Drives sample/clear commands and coefficient writes over valid/ready
// channels with random idle cycles on both sides. Every result is checked against an
// in-bench fixed-point model of the third-order filter or a value given in its row.
// ----------------------------------------------------------------------------
module tb;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  // unmapped index, dropped
  localparam logic [iirdf1_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam logic signed [iirdf1_pkg::COEF_W-1:0]   COEF_MAX = 18'sh1FFFF;
  localparam logic signed [iirdf1_pkg::COEF_W-1:0]   COEF_MIN = 18'sh20000;
  localparam logic signed [iirdf1_pkg::COEF_W-1:0]   COEF_ONE = 18'sh10000;
  localparam logic signed [iirdf1_pkg::SAMPLE_W-1:0] SMP_MAX  = 16'sh7FFF;
  localparam logic signed [iirdf1_pkg::SAMPLE_W-1:0] SMP_MIN  = 16'sh8000;

  localparam iirdf1_pkg::cfg_reg_e COEF_REGS [iirdf1_pkg::NUM_COEF] = '{
    iirdf1_pkg::REG_B0, iirdf1_pkg::REG_B1, iirdf1_pkg::REG_B2, iirdf1_pkg::REG_B3,
    iirdf1_pkg::REG_A1, iirdf1_pkg::REG_A2, iirdf1_pkg::REG_A3
  };

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 15;
  localparam int PHASE_ITEMS = 60;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] y;
    logic                                   clip;
  } filt_out_t;

  typedef struct {
    row_kind_e                              kind;
    logic [iirdf1_pkg::CFG_IDX_W-1:0]       idx;
    logic [iirdf1_pkg::COEF_W-1:0]          data;
    logic                                   cmd;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample;
    logic                                   typed;   // expected result given in the row
    filt_out_t                              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  iirdf1_in_if  in_ch ();
  iirdf1_out_if out_ch ();
  iirdf1_cfg_if cfg_ch ();

  iir_filter_direct_form_one u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // filter model state
  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_b [iirdf1_pkg::TAPS_DEF];
  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_a [iirdf1_pkg::TAPS_DEF];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_hist [iirdf1_pkg::TAPS_DEF];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_hist [iirdf1_pkg::TAPS_DEF];
  logic [iirdf1_pkg::TAP_W-1:0]           ring_pos;

  filt_out_t expected_filt [$];
  stim_row_t directed_rows [$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet  = 1'b0;   // no idling on either side

  always #5 clk = ~clk;

  function automatic void set_coef(input logic [iirdf1_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [iirdf1_pkg::COEF_W-1:0] data);
    case (idx)
      iirdf1_pkg::REG_B0: coef_b[0] = data;
      iirdf1_pkg::REG_B1: coef_b[1] = data;
      iirdf1_pkg::REG_B2: coef_b[2] = data;
      iirdf1_pkg::REG_B3: coef_b[3] = data;
      iirdf1_pkg::REG_A1: coef_a[1] = data;
      iirdf1_pkg::REG_A2: coef_a[2] = data;
      iirdf1_pkg::REG_A3: coef_a[3] = data;
      default: ;
    endcase
  endfunction

  function automatic filt_out_t iir_predict(
      input logic cmd, input logic signed [iirdf1_pkg::SAMPLE_W-1:0] smp);
    filt_out_t                    r;
    longint                       acc;
    longint                       y;
    int                           k;
    logic [iirdf1_pkg::TAP_W-1:0] slot;
    r.y    = '0;
    r.clip = 1'b0;
    if (cmd == CMD_CLEAR) begin
      for (k = 0; k < iirdf1_pkg::TAPS_DEF; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      ring_pos = '0;
      return r;
    end
    x_hist[ring_pos] = smp;
    acc = longint'(coef_b[0]) * longint'(smp);
    for (k = 1; k < iirdf1_pkg::TAPS_DEF; k++) begin
      slot = ring_pos - iirdf1_pkg::TAP_W'(k);
      acc += longint'(coef_b[k]) * longint'(x_hist[slot]);
      acc -= longint'(coef_a[k]) * longint'(y_hist[slot]);
    end
    // round half up, then floor shift
    y = (acc + (longint'(1) <<< (iirdf1_pkg::COEF_FRAC - 1))) >>> iirdf1_pkg::COEF_FRAC;
    if (y > longint'(SMP_MAX)) begin
      y      = longint'(SMP_MAX);
      r.clip = 1'b1;
    end else if (y < longint'(SMP_MIN)) begin
      y      = longint'(SMP_MIN);
      r.clip = 1'b1;
    end
    r.y              = iirdf1_pkg::SAMPLE_W'(y);
    y_hist[ring_pos] = r.y;
    ring_pos         = ring_pos + 1'b1;
    return r;
  endfunction

  function automatic void add_cfg(input logic [iirdf1_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [iirdf1_pkg::COEF_W-1:0] data);
    stim_row_t row;
    row      = '{kind: ROW_CFG, idx: idx, data: data, cmd: CMD_FILTER, sample: '0,
                 typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_item(input logic cmd,
                                   input logic signed [iirdf1_pkg::SAMPLE_W-1:0] smp);
    stim_row_t row;
    row = '{kind: ROW_ITEM, idx: '0, data: '0, cmd: cmd, sample: smp,
            typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic cmd,
                                      input logic signed [iirdf1_pkg::SAMPLE_W-1:0] smp,
                                      input logic signed [iirdf1_pkg::SAMPLE_W-1:0] y,
                                      input logic clip);
    stim_row_t row;
    row = '{kind: ROW_ITEM, idx: '0, data: '0, cmd: cmd, sample: smp,
            typed: 1'b1, want: '{y: y, clip: clip}};
    directed_rows.push_back(row);
  endfunction

  // wait until every expected result has come back, input valid low
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_filt.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [iirdf1_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iirdf1_pkg::COEF_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    set_coef(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_sample(input logic cmd,
                             input logic signed [iirdf1_pkg::SAMPLE_W-1:0] smp,
                             input logic typed, input filt_out_t want);
    filt_out_t predicted;
    if (!quiet && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    predicted = iir_predict(cmd, smp);
    expected_filt.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_filt.size());
      $display("** iir_filter_direct_form_one: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin : out_check
    filt_out_t want;
    out_ch.ready <= quiet || ($urandom_range(99) >= 6);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_filt.size() == 0) begin
        $display("%0t: unexpected result filtered %0d clipped %0b", $time,
                 out_ch.filtered, out_ch.clipped);
        errors++;
      end else begin
        want = expected_filt.pop_front();
        if (out_ch.filtered !== want.y) begin
          $display("%0t: filtered mismatch, expected %0d actual %0d", $time,
                   want.y, out_ch.filtered);
          errors++;
        end
        if (out_ch.clipped !== want.clip) begin
          $display("%0t: clipped mismatch, expected %0b actual %0b", $time,
                   want.clip, out_ch.clipped);
          errors++;
        end
      end
    end
  end

  initial begin
    int                                     phase;
    int                                     n;
    int                                     k;
    int                                     sel;
    logic [iirdf1_pkg::COEF_W-1:0]          c;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] s;
    logic                                   cmd;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_FILTER;
    in_ch.sample  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    for (k = 0; k < iirdf1_pkg::NUM_COEF; k++) begin
      set_coef(COEF_REGS[k], iirdf1_pkg::COEF_RESET[k]);
    end
    coef_a[0] = '0;
    for (k = 0; k < iirdf1_pkg::TAPS_DEF; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
    ring_pos = '0;

    // reset coefficients, zero history
    add_checked(CMD_CLEAR, 16'sd0, 16'sd0, 1'b0);
    add_checked(CMD_FILTER, 16'sd0, 16'sd0, 1'b0);
    add_item(CMD_FILTER, SMP_MAX);
    add_item(CMD_FILTER, SMP_MIN);
    add_item(CMD_FILTER, 16'sd1);
    add_item(CMD_FILTER, -16'sd1);
    add_item(CMD_FILTER, 16'sh5555);
    add_item(CMD_FILTER, 16'shAAAA);
    add_checked(CMD_CLEAR, SMP_MAX, 16'sd0, 1'b0);   // sample ignored on clear
    // pure gain of almost 2: both rails saturate
    add_cfg(iirdf1_pkg::REG_B0, COEF_MAX);
    add_cfg(iirdf1_pkg::REG_B1, '0);
    add_cfg(iirdf1_pkg::REG_B2, '0);
    add_cfg(iirdf1_pkg::REG_B3, '0);
    add_cfg(iirdf1_pkg::REG_A1, '0);
    add_cfg(iirdf1_pkg::REG_A2, '0);
    add_cfg(iirdf1_pkg::REG_A3, '0);
    add_checked(CMD_FILTER, SMP_MAX, SMP_MAX, 1'b1);
    add_checked(CMD_FILTER, SMP_MIN, SMP_MIN, 1'b1);
    add_cfg(iirdf1_pkg::REG_B0, COEF_MIN);
    add_checked(CMD_FILTER, SMP_MIN, SMP_MAX, 1'b1);
    add_checked(CMD_FILTER, SMP_MAX, SMP_MIN, 1'b1);
    add_cfg(REG_NONE, COEF_MAX);
    add_item(CMD_FILTER, 16'sd1);
    // all taps at the extremes, feedback included
    add_cfg(iirdf1_pkg::REG_A1, COEF_MIN);
    add_cfg(iirdf1_pkg::REG_A2, COEF_MAX);
    add_cfg(iirdf1_pkg::REG_A3, COEF_MIN);
    add_cfg(iirdf1_pkg::REG_B1, COEF_MAX);
    add_cfg(iirdf1_pkg::REG_B2, COEF_MIN);
    add_cfg(iirdf1_pkg::REG_B3, COEF_MAX);
    add_item(CMD_FILTER, SMP_MAX);
    add_item(CMD_FILTER, SMP_MIN);
    add_item(CMD_FILTER, 16'sh0100);
    add_item(CMD_FILTER, SMP_MAX);
    add_item(CMD_FILTER, -16'sd3);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_results();
        cfg_write(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        push_sample(directed_rows[i].cmd, directed_rows[i].sample,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      quiet = (phase >= 5 && phase < 8);
      drain_results();
      for (k = 0; k < iirdf1_pkg::NUM_COEF; k++) begin
        case (phase % 4)
          0:       c = iirdf1_pkg::COEF_RESET[k];
          1:       c = iirdf1_pkg::COEF_W'($urandom);
          2: begin
            sel = $urandom_range(3);
            c   = (sel == 0) ? COEF_MAX : (sel == 1) ? COEF_MIN : (sel == 2) ? COEF_ONE : '0;
          end
          default: c = iirdf1_pkg::COEF_W'(int'($urandom_range(16383)) - 8192);
        endcase
        cfg_write(COEF_REGS[k], c);
      end
      if ($urandom_range(3) == 0) cfg_write(REG_NONE, iirdf1_pkg::COEF_W'($urandom));

      for (n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_FILTER;
        sel = $urandom_range(99);
        if (sel < 70) begin
          s = iirdf1_pkg::SAMPLE_W'($urandom);
        end else if (sel < 85) begin
          s = iirdf1_pkg::SAMPLE_W'(int'($urandom_range(511)) - 256);
        end else begin
          case ($urandom_range(4))
            0:       s = SMP_MAX;
            1:       s = SMP_MIN;
            2:       s = 16'sd1;
            3:       s = -16'sd1;
            default: s = '0;
          endcase
        end
        if ($urandom_range(99) == 0) drain_results();
        push_sample(cmd, s, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_filt.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_filt.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_filt.size());
      errors++;
    end
    if (errors == 0) begin
      $display("** iir_filter_direct_form_one: PASSED **");
    end else begin
      $display("** iir_filter_direct_form_one: FAILED **");
    end
    $finish;
  end

endmodule
